/* hw/rtl/adcseq_pkg.sv */
// Package for the ADC scan sequencer with per-channel ring buffers.
// Holds the sizes, request and mode codes, pipeline structs and scan-list helpers.
// No dependencies; the top level imports it.
package adcseq_pkg;

   localparam int NUM_CHANNELS  = 8;
   localparam int CHAN_W        = 4;
   localparam int CHAN_IDX_W    = $clog2(NUM_CHANNELS);
   localparam int RING_BYTES    = 512;
   localparam int PTR_W         = $clog2(RING_BYTES);
   localparam int SAMPLE_W      = 16;
   localparam int BYTE_W        = 8;
   localparam int WORD_DEPTH    = NUM_CHANNELS * RING_BYTES / 2;
   localparam int WORD_ADDR_W   = CHAN_IDX_W + PTR_W - 1;
   localparam int MODES_W       = 16;
   localparam int GAINS_W       = 32;
   localparam int GAIN_W        = 4;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_W   = 1;
   localparam int CALIB_SAMPLES = 64;
   localparam int CALIB_SHIFT   = $clog2(CALIB_SAMPLES);
   localparam int CALIB_CNT_W   = $clog2(CALIB_SAMPLES);
   localparam int CALIB_SUM_W   = SAMPLE_W + CALIB_SHIFT;

   localparam logic [SAMPLE_W-1:0]    CALIB_MIDSCALE = 16'd2048;
   localparam logic [1:0]             EXT_MUX_TOP    = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_MODES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_GAINS = 1'b1;

   typedef enum logic [1:0] {
      KIND_CONVERT = 2'd0,
      KIND_READ    = 2'd1,
      KIND_STOP    = 2'd2,
      KIND_CALIB   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_OFF    = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_DIFF   = 2'd2,
      MODE_NO_MUX = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      MUX_NONE        = 2'd0,
      MUX_DIFF        = 2'd1,
      MUX_SINGLE_ODD  = 2'd2,
      MUX_SINGLE_EVEN = 2'd3
   } mux_type;

   // Request in flight between acceptance and the ring-buffer access.
   typedef struct packed {
      kind_type              kind;
      logic                  stored;
      logic                  read_ok;
      logic [CHAN_IDX_W-1:0] chan_idx;
      logic [SAMPLE_W-1:0]   conv_value;
      logic [CHAN_W-1:0]     stored_channel;
      logic [CHAN_W-1:0]     next_channel;
      logic                  mux_update;
      mux_type               mux_select;
      logic [GAIN_W-1:0]     gain_code;
      logic [1:0]            ext_mux;
      logic                  calib_done;
   } s1_type;

   // Response held in the output stage; the read byte comes from the store.
   typedef struct packed {
      logic              stored;
      logic [CHAN_W-1:0] stored_channel;
      logic [CHAN_W-1:0] next_channel;
      logic              mux_update;
      mux_type           mux_select;
      logic [GAIN_W-1:0] gain_code;
      logic [1:0]        ext_mux;
      logic              read_valid;
      logic              byte_lo;
      logic [PTR_W-1:0]  bytes_waiting;
      logic              calib_done;
   } rsp_type;

   // Channel number at position pos of the scan list, zero past its end.
   function automatic logic [CHAN_W-1:0] list_entry(input logic [MODES_W-1:0] modes,
                                                     input logic [CHAN_W-1:0] pos);
      logic [CHAN_W-1:0] n;
      logic [CHAN_W-1:0] ch;
      n  = '0;
      ch = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (modes[2*i +: 2] != MODE_OFF) begin
            if (n == pos && ch == '0) begin
               ch = CHAN_W'(i + 1);
            end
            n = n + 1'b1;
         end
      end
      return ch;
   endfunction

   function automatic mode_type chan_mode(input logic [MODES_W-1:0] modes,
                                          input logic [CHAN_IDX_W-1:0] idx);
      return mode_type'(modes[{idx, 1'b0} +: 2]);
   endfunction

   function automatic logic [GAIN_W-1:0] chan_gain(input logic [GAINS_W-1:0] gains,
                                                   input logic [CHAN_IDX_W-1:0] idx);
      return gains[{idx, 2'b00} +: GAIN_W];
   endfunction

endpackage

/* hw/rtl/adcseq_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read data holds while the read enable is low. Depends on nothing.
module adcseq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/adc_scan_sequencer_ring_buffers.sv */
// Top level of the ADC scan sequencer with per-channel byte ring buffers.
// Uses adcseq_pkg and two adcseq_ram instances (ring pointers, sample words).
//
//   channel   direction  handshake             payload
//   req_*     in         req_valid/req_ready   kind, adc_value, read_channel
//   rsp_*     out        rsp_valid/rsp_ready   one response per request
//   csr_*     in         csr_write_en          csr_index, csr_wdata
//
// One request per clock cycle is taken while the response is not stalled; each request
// passes through the s1 and s2 registers to its response. The pointer memory is read
// at acceptance and written back from the ring access stage, with forwarding of the last write.
// Reset clears the scan, offset and calibration state and the pointer valid bits;
// the sample store is not cleared, so the block is ready right after reset.
// A stalled response freezes the whole pipeline, and req_ready drops with it.
module adc_scan_sequencer_ring_buffers
   import adcseq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_kind,
   input  logic [SAMPLE_W-1:0]    req_adc_value,
   input  logic [CHAN_W-1:0]      req_read_channel,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_stored,
   output logic [CHAN_W-1:0]      rsp_stored_channel,
   output logic [CHAN_W-1:0]      rsp_next_channel,
   output logic                   rsp_mux_update,
   output logic [1:0]             rsp_mux_select,
   output logic [GAIN_W-1:0]      rsp_gain_code,
   output logic [1:0]             rsp_ext_mux,
   output logic [BYTE_W-1:0]      rsp_read_byte,
   output logic                   rsp_read_valid,
   output logic [PTR_W-1:0]       rsp_bytes_waiting,
   output logic                   rsp_calib_done,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Scan, configuration and calibration state.
   logic [CHAN_IDX_W-1:0]  scan_pos_ff, scan_pos_in;
   mode_type               last_mode_ff, last_mode_in;
   logic [MODES_W-1:0]     modes_ff, modes_in;
   logic [GAINS_W-1:0]     gains_ff, gains_in;
   logic [SAMPLE_W-1:0]    offset_ff, offset_in;
   logic [CALIB_SUM_W-1:0] calib_sum_ff, calib_sum_in;
   logic [CALIB_CNT_W-1:0] calib_count_ff, calib_count_in;

   // Pipeline stages.
   logic    s1_valid_ff, s1_valid_in;
   s1_type  s1_ff, s1_in;
   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_ff, s2_in;

   // Pointer memory bookkeeping.
   logic [NUM_CHANNELS-1:0] ptr_ok_ff, ptr_ok_in;
   logic                    fwd_valid_ff, fwd_valid_in;
   logic [CHAN_IDX_W-1:0]   fwd_idx_ff, fwd_idx_in;
   logic [2*PTR_W-1:0]      fwd_data_ff, fwd_data_in;

   logic                   advance;
   logic                   accept;
   kind_type               kind;
   logic [CHAN_W-1:0]      cur_ch;
   logic [CHAN_W-1:0]      pos_plus;
   logic [CHAN_IDX_W-1:0]  new_pos;
   logic [CHAN_W-1:0]      nxt_ch;
   logic [CHAN_IDX_W-1:0]  nxt_idx;
   mode_type               nxt_mode;
   logic                   rd_in_range;
   logic [CALIB_SUM_W-1:0] calib_sum_next;
   logic                   calib_last;

   logic [2*PTR_W-1:0]     ptr_rd_data;
   logic [2*PTR_W-1:0]     ptr_q;
   logic [PTR_W-1:0]       wp;
   logic [PTR_W-1:0]       rp;
   logic [PTR_W-1:0]       ring_len;
   logic                   read_hit;
   logic                   ptr_we;
   logic [2*PTR_W-1:0]     ptr_wdata;
   logic                   sample_we;
   logic                   sample_re;
   logic [WORD_ADDR_W-1:0] sample_waddr;
   logic [WORD_ADDR_W-1:0] sample_raddr;
   logic [SAMPLE_W-1:0]    sample_rd_data;

   assign advance   = !s2_valid_ff || rsp_ready;
   assign accept    = req_valid && advance;
   assign req_ready = advance;
   assign kind      = kind_type'(req_kind);

   // Scan list lookups for the current and the following conversion.
   always_comb begin
      cur_ch   = list_entry(modes_ff, {1'b0, scan_pos_ff});
      pos_plus = {1'b0, scan_pos_ff} + 1'b1;
      if (pos_plus[CHAN_W-1] || list_entry(modes_ff, pos_plus) == '0) begin
         new_pos = '0;
      end else begin
         new_pos = pos_plus[CHAN_IDX_W-1:0];
      end
      nxt_ch      = list_entry(modes_ff, {1'b0, new_pos});
      nxt_idx     = CHAN_IDX_W'(nxt_ch - 1'b1);
      nxt_mode    = chan_mode(modes_ff, nxt_idx);
      rd_in_range = req_read_channel != '0 && req_read_channel <= CHAN_W'(NUM_CHANNELS);
      calib_sum_next = calib_sum_ff + CALIB_SUM_W'(req_adc_value);
      calib_last     = calib_count_ff == CALIB_CNT_W'(CALIB_SAMPLES - 1);
   end

   // Acceptance stage: scan, configuration and calibration updates.
   always_comb begin
      scan_pos_in    = scan_pos_ff;
      last_mode_in   = last_mode_ff;
      modes_in       = modes_ff;
      gains_in       = gains_ff;
      offset_in      = offset_ff;
      calib_sum_in   = calib_sum_ff;
      calib_count_in = calib_count_ff;
      s1_in          = '0;
      s1_in.kind     = kind;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CHANNEL_MODES: modes_in = csr_wdata[MODES_W-1:0];
            CSR_CHANNEL_GAINS: gains_in = csr_wdata[GAINS_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         unique case (kind)
            KIND_CONVERT: begin
               scan_pos_in = new_pos;
               if (nxt_ch != '0) begin
                  last_mode_in          = nxt_mode;
                  s1_in.next_channel    = nxt_ch;
                  s1_in.mux_update      = nxt_mode != last_mode_ff;
                  s1_in.gain_code       = chan_gain(gains_ff, nxt_idx);
                  s1_in.ext_mux         = EXT_MUX_TOP - nxt_idx[CHAN_IDX_W-1:1];
                  case (nxt_mode)
                     MODE_DIFF:   s1_in.mux_select = MUX_DIFF;
                     MODE_SINGLE: s1_in.mux_select = nxt_ch[0] ? MUX_SINGLE_ODD
                                                               : MUX_SINGLE_EVEN;
                     default:     s1_in.mux_select = MUX_NONE;
                  endcase
               end
               if (cur_ch != '0) begin
                  s1_in.stored         = 1'b1;
                  s1_in.stored_channel = cur_ch;
                  s1_in.chan_idx       = CHAN_IDX_W'(cur_ch - 1'b1);
                  s1_in.conv_value     = req_adc_value + offset_ff;
               end
            end
            KIND_READ: begin
               s1_in.read_ok  = rd_in_range;
               s1_in.chan_idx = CHAN_IDX_W'(req_read_channel - 1'b1);
            end
            KIND_STOP: begin
               scan_pos_in = '0;
               modes_in    = '0;
            end
            KIND_CALIB: begin
               if (calib_last) begin
                  offset_in        = CALIB_MIDSCALE - calib_sum_next[CALIB_SUM_W-1:CALIB_SHIFT];
                  calib_sum_in     = '0;
                  calib_count_in   = '0;
                  s1_in.calib_done = 1'b1;
               end else begin
                  calib_sum_in   = calib_sum_next;
                  calib_count_in = calib_count_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // Ring access stage: read-modify-write of the channel's pointer pair.
   always_comb begin
      if (fwd_valid_ff && fwd_idx_ff == s1_ff.chan_idx) begin
         ptr_q = fwd_data_ff;
      end else if (ptr_ok_ff[s1_ff.chan_idx]) begin
         ptr_q = ptr_rd_data;
      end else begin
         ptr_q = '0;
      end
      wp       = ptr_q[2*PTR_W-1:PTR_W];
      rp       = ptr_q[PTR_W-1:0];
      ring_len = wp - rp;
      read_hit = s1_ff.read_ok && ring_len != '0;

      sample_we    = advance && s1_valid_ff && s1_ff.stored;
      sample_re    = advance && s1_valid_ff && read_hit;
      sample_waddr = {s1_ff.chan_idx, wp[PTR_W-1:1]};
      sample_raddr = {s1_ff.chan_idx, rp[PTR_W-1:1]};
      ptr_we       = advance && s1_valid_ff && (s1_ff.stored || read_hit);
      if (s1_ff.stored) begin
         ptr_wdata = {wp + PTR_W'(2), rp};
      end else begin
         ptr_wdata = {wp, rp + 1'b1};
      end

      ptr_ok_in    = ptr_ok_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_idx_in   = fwd_idx_ff;
      fwd_data_in  = fwd_data_ff;
      if (advance) begin
         fwd_valid_in = ptr_we;
         fwd_idx_in   = s1_ff.chan_idx;
         fwd_data_in  = ptr_wdata;
         if (s1_valid_ff && s1_ff.kind == KIND_STOP) begin
            ptr_ok_in = '0;
         end else if (ptr_we) begin
            ptr_ok_in[s1_ff.chan_idx] = 1'b1;
         end
      end

      s2_in.stored         = s1_ff.stored;
      s2_in.stored_channel = s1_ff.stored_channel;
      s2_in.next_channel   = s1_ff.next_channel;
      s2_in.mux_update     = s1_ff.mux_update;
      s2_in.mux_select     = s1_ff.mux_select;
      s2_in.gain_code      = s1_ff.gain_code;
      s2_in.ext_mux        = s1_ff.ext_mux;
      s2_in.read_valid     = read_hit;
      s2_in.byte_lo        = rp[0];
      s2_in.bytes_waiting  = read_hit ? ring_len - 1'b1 : '0;
      s2_in.calib_done     = s1_ff.calib_done;

      s1_valid_in = advance ? req_valid : s1_valid_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff    <= '0;
         last_mode_ff   <= MODE_OFF;
         modes_ff       <= '0;
         gains_ff       <= '0;
         offset_ff      <= '0;
         calib_sum_ff   <= '0;
         calib_count_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         ptr_ok_ff      <= '0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         scan_pos_ff    <= scan_pos_in;
         last_mode_ff   <= last_mode_in;
         modes_ff       <= modes_in;
         gains_ff       <= gains_in;
         offset_ff      <= offset_in;
         calib_sum_ff   <= calib_sum_in;
         calib_count_ff <= calib_count_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         ptr_ok_ff      <= ptr_ok_in;
         fwd_valid_ff   <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
      fwd_idx_ff  <= fwd_idx_in;
      fwd_data_ff <= fwd_data_in;
   end

   // Write pointer in the upper half, read pointer in the lower half.
   adcseq_ram #(
      .WIDTH (2 * PTR_W),
      .DEPTH (NUM_CHANNELS)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_we),
      .wr_addr (s1_ff.chan_idx),
      .wr_data (ptr_wdata),
      .rd_en   (advance),
      .rd_addr (s1_in.chan_idx),
      .rd_data (ptr_rd_data)
   );

   // Each word is one sample, high byte first in the ring.
   adcseq_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WORD_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (sample_we),
      .wr_addr (sample_waddr),
      .wr_data (s1_ff.conv_value),
      .rd_en   (sample_re),
      .rd_addr (sample_raddr),
      .rd_data (sample_rd_data)
   );

   assign rsp_valid          = s2_valid_ff;
   assign rsp_stored         = s2_ff.stored;
   assign rsp_stored_channel = s2_ff.stored_channel;
   assign rsp_next_channel   = s2_ff.next_channel;
   assign rsp_mux_update     = s2_ff.mux_update;
   assign rsp_mux_select     = s2_ff.mux_select;
   assign rsp_gain_code      = s2_ff.gain_code;
   assign rsp_ext_mux        = s2_ff.ext_mux;
   assign rsp_read_valid     = s2_ff.read_valid;
   assign rsp_bytes_waiting  = s2_ff.bytes_waiting;
   assign rsp_calib_done     = s2_ff.calib_done;
   assign rsp_read_byte      = !s2_ff.read_valid ? '0 :
                               s2_ff.byte_lo ? sample_rd_data[BYTE_W-1:0]
                                             : sample_rd_data[SAMPLE_W-1:BYTE_W];

`ifndef SYNTHESIS
   // A stalled response must keep its fields and the byte read from the store.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !rsp_ready |=> s2_valid_ff && $stable(s2_ff) && $stable(rsp_read_byte))
      else $error("stalled response changed");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_STOP |=> modes_ff == '0 && scan_pos_ff == '0)
      else $error("stop did not clear the scan");

   a_calib_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_CALIB && calib_last |=> calib_count_ff == '0 && calib_sum_ff == '0)
      else $error("calibration did not restart");

   // Forwarded pointers always belong to an entry that is live.
   a_fwd_live: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> ptr_ok_ff[fwd_idx_ff])
      else $error("forwarding from a cleared pointer entry");

   a_no_next_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_channel == '0 |-> !rsp_mux_update && rsp_mux_select == MUX_NONE
         && rsp_gain_code == '0 && rsp_ext_mux == '0)
      else $error("mux fields set without a next channel");
`endif

endmodule
